// ----- src/pidml_pkg.sv -----
// shared types, constants and helpers of the pid step unit
`timescale 1ns / 1ps
package pidml_pkg;

  localparam int FRAC_BITS = 16;
  localparam int GW        = 32;   // gain and range register width
  localparam int EW        = 40;   // error, integral and control width
  localparam int TW        = 52;   // signed gain term width
  localparam int CW        = 6;    // step counter width

  localparam int MAP_STEPS = 33;   // one quotient bit per step
  localparam int MUL_STEPS = 6;    // one byte of the multiplier per step
  localparam int DIV_STEPS = 13;   // one nibble of the dividend per step

  // register indexes
  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_FEED_MIN = 3'd1;
  localparam logic [2:0] REG_FEED_MAX = 3'd2;
  localparam logic [2:0] REG_DEST_MIN = 3'd3;
  localparam logic [2:0] REG_DEST_MAX = 3'd4;
  localparam logic [2:0] REG_GAIN_P   = 3'd5;
  localparam logic [2:0] REG_GAIN_I   = 3'd6;
  localparam logic [2:0] REG_GAIN_D   = 3'd7;

  // modes
  localparam logic [1:0] MODE_MAP  = 2'd0;
  localparam logic [1:0] MODE_ALT  = 2'd1;
  localparam logic [1:0] MODE_HDG  = 2'd2;
  localparam logic [1:0] MODE_CASC = 2'd3;

  // commands
  localparam logic FUNC_STEP  = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  // product selector
  localparam logic [1:0] TERM_P = 2'd0;
  localparam logic [1:0] TERM_I = 2'd1;
  localparam logic [1:0] TERM_D = 2'd2;

  // register reset values
  localparam logic signed [GW-1:0] FEED_MIN_RST = -32'sd60 <<< FRAC_BITS;
  localparam logic signed [GW-1:0] FEED_MAX_RST = 32'sd60 <<< FRAC_BITS;
  localparam logic signed [GW-1:0] DEST_MIN_RST = 32'sd1000 <<< FRAC_BITS;
  localparam logic signed [GW-1:0] DEST_MAX_RST = 32'sd2000 <<< FRAC_BITS;

  // fixed point constants
  localparam logic signed [EW:0]   HALF_TURN  = 41'sd180 <<< FRAC_BITS;
  localparam logic signed [EW:0]   FULL_TURN  = 41'sd360 <<< FRAC_BITS;
  localparam logic signed [EW:0]   INT_LIM    = 41'sd250 <<< FRAC_BITS;
  localparam logic signed [TW+1:0] CTL_OFFSET = 54'sd1500 <<< FRAC_BITS;
  localparam logic signed [TW+1:0] CTL_LOW    = 54'sd1205 <<< FRAC_BITS;
  localparam logic signed [TW+1:0] CTL_HIGH   = 54'sd1795 <<< FRAC_BITS;
  localparam logic [63:0]          TERM_LIM   = 64'd1 << 50;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MAP, ST_MFIN, ST_PREP, ST_MSET, ST_MUL, ST_MEND,
    ST_DIV, ST_SCALE, ST_SUM, ST_DONE
  } state_t;

  // saturate a 41-bit signed value to 40 bits
  function automatic logic signed [EW-1:0] sat40(input logic signed [EW:0] v);
    logic signed [EW-1:0] r;
    if (v[EW] != v[EW-1]) r = v[EW] ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
    else r = v[EW-1:0];
    return r;
  endfunction

  // radix-16 digit step of a divide by five: {quotient digit, remainder}
  function automatic logic [6:0] div5(input logic [6:0] t);
    logic [3:0] q;
    logic [6:0] prod;
    q = 4'd0;
    for (int k = 1; k < 16; k++) begin
      if (t >= 7'(k * 5)) q = 4'(k);
    end
    prod = 7'(q) * 7'd5;
    return {q, 3'(t - prod)};
  endfunction

endpackage

// ----- src/pid_step_with_mapping_and_limits_unit.sv -----
// pid step unit: feedback mapping, shared multiplier, serial dividers, output limits
// sequence: a control step runs the three gain products on the shared multiplier;
//   mode 0 with feedback inside the range adds a bit-serial scaling divide first,
//   later steps add a nibble-serial divide by 20; a clear goes straight to the result
// throughput: one transaction at a time, set by the shared 32x8 multiplier and dividers
// reset: synchronous active-low; registers return to defaults, integral and last error 0
`timescale 1ns / 1ps
module pid_step_with_mapping_and_limits_unit
  import pidml_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [2:0]           cfg_index,
  input  logic [GW-1:0]        cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_func,
  input  logic [15:0]          in_setpoint,
  input  logic signed [GW-1:0] in_feedback,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [EW-1:0] out_control,
  output logic signed [EW-1:0] out_error_now,
  output logic                 out_integral_limited
);

  // configuration registers
  logic [1:0]           mode_r;
  logic signed [GW-1:0] feed_min_r, feed_max_r, dest_min_r, dest_max_r;
  logic signed [GW-1:0] gain_p_r, gain_i_r, gain_d_r;

  // loop state
  logic signed [EW-1:0] integ_r, prev_r;
  logic                 first_r;

  // sequencer
  state_t     state_r, state_nxt;
  logic [CW-1:0] cnt_r;
  logic [1:0] midx_r;

  // working registers
  logic [15:0]          sp_r;
  logic signed [33:0]   fb_r;
  logic [31:0]          ma_r, ms_r, mr_r;
  logic [32:0]          mb_r, mq_r;
  logic                 dneg_r;
  logic signed [EW-1:0] err_r, isum_r;
  logic signed [EW:0]   delta_r;
  logic [31:0]          ga_r;
  logic [47:0]          xb_r;
  logic [79:0]          acc_r;
  logic                 pneg_r;
  logic signed [TW-1:0] p_r, i_r, d_r;
  logic [51:0]          dv_r, dq_r;
  logic [2:0]           drem_r;

  // result registers
  logic signed [EW-1:0] res_ctl_r, res_err_r;
  logic                 res_lim_r;
  logic                 out_valid_r;
  logic signed [EW-1:0] out_ctl_r, out_err_r;
  logic                 out_lim_r;

  logic in_acc, out_free, load_out;
  logic fb_le, fb_ge;
  logic [39:0] mul_pp;
  logic signed [EW-1:0] int_hi, int_lo;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign load_out = (state_r == ST_DONE) && out_free;
  assign fb_le    = in_feedback <= feed_min_r;
  assign fb_ge    = in_feedback >= feed_max_r;

  // integral limits as signed 40-bit values
  assign int_hi = INT_LIM[EW-1:0];
  assign int_lo = -int_hi;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_MAP;
      feed_min_r <= FEED_MIN_RST;
      feed_max_r <= FEED_MAX_RST;
      dest_min_r <= DEST_MIN_RST;
      dest_max_r <= DEST_MAX_RST;
      gain_p_r   <= '0;
      gain_i_r   <= '0;
      gain_d_r   <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MODE:     mode_r     <= cfg_wdata[1:0];
        REG_FEED_MIN: feed_min_r <= cfg_wdata;
        REG_FEED_MAX: feed_max_r <= cfg_wdata;
        REG_DEST_MIN: dest_min_r <= cfg_wdata;
        REG_DEST_MAX: dest_max_r <= cfg_wdata;
        REG_GAIN_P:   gain_p_r   <= cfg_wdata;
        REG_GAIN_I:   gain_i_r   <= cfg_wdata;
        REG_GAIN_D:   gain_d_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_func == FUNC_CLEAR) state_nxt = ST_DONE;
          else if (mode_r == MODE_MAP && !fb_le && !fb_ge) state_nxt = ST_MAP;
          else state_nxt = ST_PREP;
        end
      end
      ST_MAP:   if (cnt_r == '0) state_nxt = ST_MFIN;
      ST_MFIN:  state_nxt = ST_PREP;
      ST_PREP:  state_nxt = ST_MSET;
      ST_MSET:  state_nxt = ST_MUL;
      ST_MUL:   if (cnt_r == '0) state_nxt = ST_MEND;
      ST_MEND: begin
        if (midx_r != TERM_D) state_nxt = ST_MSET;
        else if (first_r) state_nxt = ST_SUM;
        else state_nxt = ST_DIV;
      end
      ST_DIV:   if (cnt_r == '0) state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // scaling divide step: two compares against the span
  logic [33:0] map_t, map_rn;
  logic [1:0]  map_d;
  always_comb begin
    map_t = {1'b0, mr_r, 1'b0} + (mb_r[32] ? {2'b0, ma_r} : 34'd0);
    if (map_t >= {1'b0, ms_r, 1'b0}) begin
      map_d  = 2'd2;
      map_rn = map_t - {1'b0, ms_r, 1'b0};
    end else if (map_t >= {2'b0, ms_r}) begin
      map_d  = 2'd1;
      map_rn = map_t - {2'b0, ms_r};
    end else begin
      map_d  = 2'd0;
      map_rn = map_t;
    end
  end

  // error and integral
  logic signed [EW:0]   sp_s, fb_s, e_raw, i_raw;
  logic signed [EW-1:0] e_sat;
  always_comb begin
    sp_s = {1'b0, 40'(sp_r) << FRAC_BITS};
    fb_s = {{(EW+1-34){fb_r[33]}}, fb_r};
    e_raw = sp_s - fb_s;
    if (mode_r == MODE_HDG) begin
      if (e_raw < -HALF_TURN) e_raw = e_raw + FULL_TURN;
      else if (e_raw >= HALF_TURN) e_raw = e_raw - FULL_TURN;
    end
    e_sat = sat40(e_raw);
    i_raw = {integ_r[EW-1], integ_r} + {e_sat[EW-1], e_sat};
  end

  // operand select for the shared multiplier
  logic signed [EW:0]   mul_x;
  logic signed [GW-1:0] mul_g;
  logic [EW:0]          mul_xa;
  always_comb begin
    case (midx_r)
      TERM_P:  begin mul_x = {err_r[EW-1], err_r};   mul_g = gain_p_r; end
      TERM_I:  begin mul_x = {isum_r[EW-1], isum_r}; mul_g = gain_i_r; end
      default: begin mul_x = delta_r;                mul_g = gain_d_r; end
    endcase
    mul_xa = mul_x[EW] ? (EW+1)'(-mul_x) : mul_x;
  end

  // 32x8 partial product of the shared multiplier
  assign mul_pp = ga_r * xb_r[47:40];

  // product shift, term saturation and sign
  logic [63:0]         prod_sh;
  logic [50:0]         prod_mag;
  logic signed [TW-1:0] prod_term;
  always_comb begin
    prod_sh   = acc_r[79:FRAC_BITS];
    prod_mag  = (prod_sh > TERM_LIM) ? TERM_LIM[50:0] : prod_sh[50:0];
    prod_term = pneg_r ? -$signed({1'b0, prod_mag}) : $signed({1'b0, prod_mag});
  end

  // divide-by-five digit and times-20 scaling of the derivative
  logic [6:0]  dig_qr;
  logic [TW-1:0] i_mag, d_mag;
  logic [55:0] d20;
  logic [50:0] d20_mag;
  always_comb begin
    dig_qr  = div5({drem_r, dv_r[51:48]});
    i_mag   = i_r[TW-1] ? TW'(-i_r) : i_r;
    d_mag   = d_r[TW-1] ? TW'(-d_r) : d_r;
    d20     = (56'(d_mag) << 4) + (56'(d_mag) << 2);
    d20_mag = (d20 > 56'(TERM_LIM)) ? TERM_LIM[50:0] : d20[50:0];
  end

  // sum and output limits
  logic signed [TW+1:0] sum_s, sum_o;
  logic signed [EW-1:0] ctl_v;
  always_comb begin
    sum_s = {{2{p_r[TW-1]}}, p_r} + {{2{i_r[TW-1]}}, i_r} + {{2{d_r[TW-1]}}, d_r};
    sum_o = sum_s + CTL_OFFSET;
    if (mode_r == MODE_ALT || mode_r == MODE_HDG) begin
      ctl_v = sat40(sum_s[EW:0]);
      if (sum_s > $signed((TW+2)'({1'b0, {(EW-1){1'b1}}}))) ctl_v = {1'b0, {(EW-1){1'b1}}};
      else if (sum_s < -$signed((TW+2)'({1'b1, {(EW-1){1'b0}}})))
        ctl_v = {1'b1, {(EW-1){1'b0}}};
    end else begin
      if (sum_o < CTL_LOW) ctl_v = CTL_LOW[EW-1:0];
      else if (sum_o > CTL_HIGH) ctl_v = CTL_HIGH[EW-1:0];
      else ctl_v = sum_o[EW-1:0];
    end
  end

  // loop state: integral, last error, first step flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
      prev_r  <= '0;
      first_r <= 1'b1;
    end else if (state_r == ST_IDLE && in_acc && in_func == FUNC_CLEAR) begin
      integ_r <= '0;
      prev_r  <= '0;
    end else if (state_r == ST_SUM) begin
      if (isum_r >= int_hi) integ_r <= int_hi;
      else if (isum_r <= int_lo) integ_r <= int_lo;
      else integ_r <= isum_r;
      prev_r  <= err_r;
      first_r <= 1'b0;
    end
  end

  // datapath sequencing
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          sp_r <= in_setpoint;
          res_ctl_r <= '0;
          res_err_r <= '0;
          res_lim_r <= 1'b0;
          midx_r <= TERM_P;
          if (mode_r != MODE_MAP) fb_r <= 34'(in_feedback);
          else if (fb_le) fb_r <= 34'(dest_min_r);
          else if (fb_ge) fb_r <= 34'(dest_max_r);
          ma_r <= 32'(33'(feed_max_r) - 33'(in_feedback));
          ms_r <= 32'(33'(feed_max_r) - 33'(feed_min_r));
          mb_r <= (dest_max_r < dest_min_r) ? 33'(33'(dest_min_r) - 33'(dest_max_r))
                                            : 33'(33'(dest_max_r) - 33'(dest_min_r));
          dneg_r <= dest_max_r < dest_min_r;
          mr_r <= '0;
          mq_r <= '0;
          cnt_r <= CW'(MAP_STEPS - 1);
        end
      end
      ST_MAP: begin
        mr_r  <= map_rn[31:0];
        mq_r  <= {mq_r[31:0], 1'b0} + 33'(map_d);
        mb_r  <= {mb_r[31:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
      end
      ST_MFIN: begin
        fb_r <= dneg_r ? 34'(dest_max_r) + {1'b0, mq_r} : 34'(dest_max_r) - {1'b0, mq_r};
      end
      ST_PREP: begin
        err_r   <= e_sat;
        isum_r  <= sat40(i_raw);
        delta_r <= {e_sat[EW-1], e_sat} - {prev_r[EW-1], prev_r};
      end
      ST_MSET: begin
        ga_r   <= mul_g[GW-1] ? GW'(-mul_g) : mul_g;
        xb_r   <= 48'(mul_xa);
        pneg_r <= mul_g[GW-1] ^ mul_x[EW];
        acc_r  <= '0;
        cnt_r  <= CW'(MUL_STEPS - 1);
      end
      ST_MUL: begin
        acc_r <= {acc_r[71:0], 8'd0} + 80'(mul_pp);
        xb_r  <= {xb_r[39:0], 8'd0};
        cnt_r <= cnt_r - 1'b1;
      end
      ST_MEND: begin
        case (midx_r)
          TERM_P:  p_r <= prod_term;
          TERM_I:  i_r <= prod_term;
          default: d_r <= prod_term;
        endcase
        midx_r <= midx_r + 1'b1;
        dv_r   <= i_mag >> 2;
        drem_r <= '0;
        dq_r   <= '0;
        cnt_r  <= CW'(DIV_STEPS - 1);
      end
      ST_DIV: begin
        dq_r   <= {dq_r[47:0], dig_qr[6:3]};
        drem_r <= dig_qr[2:0];
        dv_r   <= {dv_r[47:0], 4'd0};
        cnt_r  <= cnt_r - 1'b1;
      end
      ST_SCALE: begin
        i_r <= i_r[TW-1] ? -$signed(dq_r) : $signed(dq_r);
        d_r <= d_r[TW-1] ? -$signed({1'b0, d20_mag}) : $signed({1'b0, d20_mag});
      end
      ST_SUM: begin
        res_ctl_r <= ctl_v;
        res_err_r <= err_r;
        res_lim_r <= (isum_r >= int_hi) || (isum_r <= int_lo);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (load_out) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ctl_r <= res_ctl_r;
      out_err_r <= res_err_r;
      out_lim_r <= res_lim_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_control          = out_ctl_r;
  assign out_error_now        = out_err_r;
  assign out_integral_limited = out_lim_r;

endmodule

// ----- verif/pid_step_checker.sv -----
// checker for the pid step unit: predicts each control result and compares it
`timescale 1ns / 1ps
module pid_step_checker
  import pidml_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [2:0]           cfg_index,
  input  logic [GW-1:0]        cfg_wdata,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 in_func,
  input  logic [15:0]          in_setpoint,
  input  logic signed [GW-1:0] in_feedback,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic signed [EW-1:0] out_control,
  input  logic signed [EW-1:0] out_error_now,
  input  logic                 out_integral_limited,
  output int                   fail_count,
  output int                   pending
);

  typedef struct packed {
    logic signed [EW-1:0] control;
    logic signed [EW-1:0] err;
    logic                 limited;
  } step_result_t;

  localparam longint W40_HI = 64'sd549755813887;
  localparam longint W40_LO = -64'sd549755813888;
  localparam longint LIM50  = 64'sd1 << 50;
  localparam longint ONE    = 64'sd1 << FRAC_BITS;

  step_result_t expected_q[$];

  // predictor copy of registers and loop state
  logic [1:0] pm_mode;
  longint     pm_fmin, pm_fmax, pm_dmin, pm_dmax, pm_kp, pm_ki, pm_kd;
  longint     pm_isum, pm_prev_err;
  bit         pm_first;

  function automatic longint clip40(longint v);
    if (v > W40_HI) return W40_HI;
    if (v < W40_LO) return W40_LO;
    return v;
  endfunction

  // linear feedback mapping, clamped at both ends, truncating
  function automatic longint map_feedback(longint f);
    logic [127:0] num;
    longint dd, q;
    if (f <= pm_fmin) return pm_dmin;
    if (f >= pm_fmax) return pm_dmax;
    dd = pm_dmax - pm_dmin;
    num = 128'(pm_fmax - f) * 128'(dd < 0 ? -dd : dd);
    q = longint'(num / 128'(pm_fmax - pm_fmin));
    return dd < 0 ? pm_dmax + q : pm_dmax - q;
  endfunction

  // gain product with truncation toward zero and term saturation
  function automatic longint gain_mul(longint a, longint b);
    logic [127:0] m;
    bit neg;
    neg = (a < 0) != (b < 0);
    m = (128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b)) >> FRAC_BITS;
    if (m > 128'(LIM50)) m = 128'(LIM50);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic step_result_t predict_step(logic func, logic [15:0] sp,
                                                logic signed [GW-1:0] fbin);
    step_result_t r;
    longint fb, e, delta, p, i, d, c, lim;
    r = '0;
    if (func == FUNC_CLEAR) begin
      pm_isum = 0;
      pm_prev_err = 0;
      return r;
    end
    fb = longint'(fbin);
    if (pm_mode == MODE_MAP) fb = map_feedback(fb);
    e = longint'(sp) * ONE - fb;
    if (pm_mode == MODE_HDG) begin
      if (e < -180 * ONE) e += 360 * ONE;
      else if (e >= 180 * ONE) e -= 360 * ONE;
    end
    e = clip40(e);
    pm_isum = clip40(pm_isum + e);
    delta = e - pm_prev_err;
    p = gain_mul(pm_kp, e);
    i = gain_mul(pm_ki, pm_isum);
    d = gain_mul(pm_kd, delta);
    if (!pm_first) begin
      i = i / 20;
      d = d * 20;
      if (d > LIM50) d = LIM50;
      if (d < -LIM50) d = -LIM50;
    end
    c = p + i + d;
    if (pm_mode == MODE_ALT || pm_mode == MODE_HDG) c = clip40(c);
    else begin
      c += 1500 * ONE;
      if (c < 1205 * ONE) c = 1205 * ONE;
      if (c > 1795 * ONE) c = 1795 * ONE;
    end
    lim = 250 * ONE;
    if (pm_isum >= lim) begin
      pm_isum = lim;
      r.limited = 1'b1;
    end else if (pm_isum <= -lim) begin
      pm_isum = -lim;
      r.limited = 1'b1;
    end
    pm_prev_err = e;
    pm_first = 1'b0;
    r.control = c[EW-1:0];
    r.err = e[EW-1:0];
    return r;
  endfunction

  assign pending = expected_q.size();

  // watch config writes, input and result transactions
  always @(posedge clk) begin
    step_result_t want;
    if (!rst_n) begin
      pm_mode = MODE_MAP;
      pm_fmin = longint'(FEED_MIN_RST);
      pm_fmax = longint'(FEED_MAX_RST);
      pm_dmin = longint'(DEST_MIN_RST);
      pm_dmax = longint'(DEST_MAX_RST);
      pm_kp = 0;
      pm_ki = 0;
      pm_kd = 0;
      pm_isum = 0;
      pm_prev_err = 0;
      pm_first = 1'b1;
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_MODE:     pm_mode = cfg_wdata[1:0];
          REG_FEED_MIN: pm_fmin = longint'($signed(cfg_wdata));
          REG_FEED_MAX: pm_fmax = longint'($signed(cfg_wdata));
          REG_DEST_MIN: pm_dmin = longint'($signed(cfg_wdata));
          REG_DEST_MAX: pm_dmax = longint'($signed(cfg_wdata));
          REG_GAIN_P:   pm_kp = longint'($signed(cfg_wdata));
          REG_GAIN_I:   pm_ki = longint'($signed(cfg_wdata));
          REG_GAIN_D:   pm_kd = longint'($signed(cfg_wdata));
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result transaction: control %0d error %0d",
                     out_control, out_error_now);
        end else begin
          want = expected_q.pop_front();
          if (out_control !== want.control || out_error_now !== want.err ||
              out_integral_limited !== want.limited) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: control exp %0d got %0d, error exp %0d got %0d, lim exp %0b got %0b",
                       want.control, out_control, want.err, out_error_now,
                       want.limited, out_integral_limited);
          end
        end
      end
      if (in_valid && !in_stall)
        expected_q.push_back(predict_step(in_func, in_setpoint, in_feedback));
    end
  end

endmodule

// ----- verif/pid_step_with_mapping_and_limits_unit_tb.sv -----
// testbench top: stimulus, configuration phases and verdict for the pid step unit
`timescale 1ns / 1ps
module pid_step_with_mapping_and_limits_unit_tb;
  import pidml_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [2:0]           cfg_index = REG_MODE;
  logic [GW-1:0]        cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_func = FUNC_STEP;
  logic [15:0]          in_setpoint = '0;
  logic signed [GW-1:0] in_feedback = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [EW-1:0] out_control;
  logic signed [EW-1:0] out_error_now;
  logic                 out_integral_limited;
  int                   fail_count;
  int                   pending;
  bit                   stall_random = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  pid_step_with_mapping_and_limits_unit u_dut (.*);

  pid_step_checker u_chk (.*);

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  // receiver stall pattern
  always @(posedge clk) begin
    if (stall_random && $urandom_range(0, 99) < 30) out_stall <= 1'b1;
    else out_stall <= 1'b0;
  end

  task automatic wait_cycles(int n);
    repeat (n) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [GW-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // one control transaction through the input channel, then a random gap, possibly none
  task automatic send_step(logic func, logic [15:0] sp, logic [GW-1:0] fb);
    int n;
    in_valid <= 1'b1;
    in_func <= func;
    in_setpoint <= sp;
    in_feedback <= fb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n = gap_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      wait_cycles(n);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    wait_cycles(10);
  endtask

  function automatic logic [GW-1:0] rand_word();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      2: return 32'($signed($urandom_range(0, 400)) - 200) <<< FRAC_BITS;
      default: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
    endcase
  endfunction

  task automatic set_gains(logic [GW-1:0] kp, logic [GW-1:0] ki, logic [GW-1:0] kd);
    write_reg(REG_GAIN_P, kp);
    write_reg(REG_GAIN_I, ki);
    write_reg(REG_GAIN_D, kd);
  endtask

  // random step sequence with occasional clears
  task automatic random_run(int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 19) == 0)
        send_step(FUNC_CLEAR, 16'($urandom()), 32'($urandom()));
      else if ($urandom_range(0, 3) == 0)
        send_step(FUNC_STEP, 16'($urandom()), rand_word());
      else
        send_step(FUNC_STEP, 16'($urandom_range(0, 400)), rand_word());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset registers, range ends and inside the range
    send_step(FUNC_STEP, 16'd1500, 32'h80000000);
    send_step(FUNC_STEP, 16'd1500, 32'h7fffffff);
    send_step(FUNC_STEP, 16'd1500, 32'sd12 <<< FRAC_BITS);
    send_step(FUNC_STEP, 16'd0, -(32'sd60 <<< FRAC_BITS));
    send_step(FUNC_CLEAR, 16'hffff, 32'hffffffff);
    drain();

    // inverted and empty ranges, negative destination span, large gains
    write_reg(REG_FEED_MIN, 32'sd10 <<< FRAC_BITS);
    write_reg(REG_FEED_MAX, 32'sd10 <<< FRAC_BITS);
    write_reg(REG_DEST_MIN, 32'h7fffffff);
    write_reg(REG_DEST_MAX, 32'h80000000);
    set_gains(32'h7fffffff, 32'h80000000, 32'h7fffffff);
    send_step(FUNC_STEP, 16'd0, 32'sd10 <<< FRAC_BITS);
    send_step(FUNC_STEP, 16'hffff, 32'sd9 <<< FRAC_BITS);
    drain();
    write_reg(REG_FEED_MIN, 32'sd50 <<< FRAC_BITS);
    write_reg(REG_FEED_MAX, -(32'sd50 <<< FRAC_BITS));
    send_step(FUNC_STEP, 16'd3, 32'd0);
    drain();

    // altitude: integral clamp exactly at the limit and beyond
    write_reg(REG_MODE, 32'(MODE_ALT));
    set_gains(32'sd1 <<< FRAC_BITS, 32'sd1 <<< FRAC_BITS, 32'sd1 <<< FRAC_BITS);
    send_step(FUNC_CLEAR, 16'd0, 32'd0);
    send_step(FUNC_STEP, 16'd250, 32'd0);
    send_step(FUNC_STEP, 16'd0, 32'sd249 <<< FRAC_BITS);
    send_step(FUNC_STEP, 16'hffff, 32'h80000000);
    send_step(FUNC_STEP, 16'd0, 32'h7fffffff);
    drain();

    // heading: wrap at both sides including exactly 180
    write_reg(REG_MODE, 32'(MODE_HDG));
    send_step(FUNC_STEP, 16'd180, 32'd0);
    send_step(FUNC_STEP, 16'd0, 32'sd181 <<< FRAC_BITS);
    send_step(FUNC_STEP, 16'd0, 32'sd180 <<< FRAC_BITS);
    send_step(FUNC_STEP, 16'd359, 32'd0);
    drain();

    // cascade: output limits on both sides
    write_reg(REG_MODE, 32'(MODE_CASC));
    send_step(FUNC_STEP, 16'hffff, 32'h80000000);
    send_step(FUNC_STEP, 16'd0, 32'h7fffffff);
    send_step(FUNC_STEP, 16'd1500, 32'sd1500 <<< FRAC_BITS);
    drain();

    // random phases over all modes and register settings
    for (int ph = 0; ph < 16; ph++) begin
      drain();
      write_reg(REG_MODE, 32'(ph[1:0]));
      write_reg(REG_FEED_MIN, $urandom_range(0, 3) == 0 ? rand_word()
                : -(32'($urandom_range(1, 200)) <<< FRAC_BITS));
      write_reg(REG_FEED_MAX, $urandom_range(0, 3) == 0 ? rand_word()
                : 32'($urandom_range(1, 200)) <<< FRAC_BITS);
      write_reg(REG_DEST_MIN, rand_word());
      write_reg(REG_DEST_MAX, rand_word());
      set_gains(rand_word(), rand_word(), rand_word());
      stall_random = (ph % 4 != 3);
      random_run(33);
      if (ph == 7) drain();
    end
    drain();
    stall_random = 1'b0;
    wait_cycles(100);

    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #3000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
